// ===== hdl/pgc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgc_pkg
// shared types and codes of the palette color lookup table with gamma
// ----------------------------------------------------------------------------
package pgc_pkg;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // item kinds
  localparam logic [1:0] OP_SET_IDX = 2'd0;
  localparam logic [1:0] OP_SET_DIR = 2'd1;
  localparam logic [1:0] OP_GET     = 2'd2;
  localparam logic [1:0] OP_LOAD    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_EN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_3CH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_BITS = 3'd4;

  // luminance weights, 0.16 fixed point
  localparam logic [15:0] W_RED   = 16'h4ccc;
  localparam logic [15:0] W_GREEN = 16'h970a;
  localparam logic [15:0] W_BLUE  = 16'h1c29;

  localparam logic [7:0] MID_GRAY = 8'd127;
  localparam logic [3:0] MAX_INDEX_BITS = 4'd8;

  typedef struct packed {
    logic [5:0]  pad;
    logic [7:0]  gamma_value;
    logic [1:0]  gamma_channel;
    logic [15:0] blue_in;
    logic [15:0] green_in;
    logic [15:0] red_in;
    logic [7:0]  entry_index;
  } in_data_t;

  typedef struct packed {
    logic [15:0] blue_out;
    logic [15:0] green_out;
    logic [15:0] red_out;
  } out_data_t;

endpackage

// ===== hdl/palette_gamma_clut.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_gamma_clut
// rgb palette ram with luminance mapping and gamma tables
// ----------------------------------------------------------------------------
//  channel  signals                       moves
//  s        s_tvalid s_tready s_tdata     one command beat, kind in s_tuser
//  m        m_tvalid m_tready m_tdata     one result beat, status in m_tuser
//  cfg      cfg_we cfg_index cfg_data     register write, no handshake
//
//  one command at a time: get, load and rejected set pass one result state;
//  a set: multiply, sum, gamma if on (three gamma ram reads, one a cycle), write
//  after reset a fill pass fills both rams, s_tready stays low meanwhile
//  a result waiting on m_tready holds the sequencer in its last state
// ----------------------------------------------------------------------------
module palette_gamma_clut
  import pgc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256,
  parameter int GAMMA_CHANNELS  = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // entry_index, red_in, green_in, blue_in, gamma_channel, gamma_value
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // opcode
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // red_out, green_out, blue_out
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status
  output logic                  m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PAL_W = $clog2(PALETTE_ENTRIES);
  localparam int TBL_W = (GAMMA_CHANNELS > 1) ? $clog2(GAMMA_CHANNELS) : 1;
  localparam int ROW_W = 8 * GAMMA_CHANNELS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_GAM   = 3'd4;
  localparam logic [2:0] ST_WR    = 3'd5;
  localparam logic [2:0] ST_GET   = 3'd6;
  localparam logic [2:0] ST_RES   = 3'd7;

  in_data_t s_data;
  logic [2:0] state;
  logic [7:0] clr_cnt;
  logic luma_en, direct, gamma_en, gamma_3ch;
  logic [3:0] index_bits;
  logic [7:0] item_idx;
  logic [7:0] col_r, col_g, col_b;
  logic [23:0] p_r, p_g, p_b;
  logic [23:0] luma_sum;
  logic [1:0] gch;
  logic [TBL_W-1:0] glane, tsel;
  logic res_status;
  logic accept, out_free, item_in_pal, clr_in_pal;
  logic res_load;
  logic [7:0] col_sel, g_byte;
  logic [3:0] bits_sat;
  logic [7:0] g_raddr;
  logic [ROW_W-1:0] g_rdata;
  logic [23:0] pal_rdata;
  logic pal_we;
  logic [PAL_W-1:0] pal_waddr, pal_raddr;
  logic [23:0] pal_wdata;
  logic load_we;

  logic [23:0]      pal_mem [PALETTE_ENTRIES];
  logic [ROW_W-1:0] gam_mem [256];

  assign s_data   = in_data_t'(s_tdata);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign res_load = out_free &&
                    ((state == ST_WR) || (state == ST_RES) || (state == ST_GET));

  assign item_in_pal = {1'b0, item_idx} < 9'(PALETTE_ENTRIES);
  assign clr_in_pal  = {1'b0, clr_cnt} < 9'(PALETTE_ENTRIES);
  assign luma_sum    = p_r + p_g + p_b;

  // gamma lookup address and table lane
  always_comb begin
    case (gch)
      2'd0:    col_sel = col_r;
      2'd1:    col_sel = col_g;
      default: col_sel = col_b;
    endcase
    bits_sat = (index_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : index_bits;
    g_raddr  = col_sel >> (MAX_INDEX_BITS - bits_sat);
    tsel     = (gamma_3ch && (32'(gch) < GAMMA_CHANNELS)) ? TBL_W'(gch) : '0;
    g_byte   = g_rdata[8*glane +: 8];
  end

  assign load_we = accept && (s_tuser == OP_LOAD) &&
                   (32'(s_data.gamma_channel) < GAMMA_CHANNELS);

  assign pal_we    = ((state == ST_CLEAR) && clr_in_pal) ||
                     ((state == ST_WR) && out_free && item_in_pal);
  assign pal_waddr = (state == ST_CLEAR) ? clr_cnt[PAL_W-1:0] : item_idx[PAL_W-1:0];
  assign pal_wdata = (state == ST_CLEAR) ? {MID_GRAY, MID_GRAY, MID_GRAY}
                                         : {col_b, col_g, col_r};
  assign pal_raddr = (state == ST_IDLE) ? s_data.entry_index[PAL_W-1:0]
                                        : item_idx[PAL_W-1:0];

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pal_waddr] <= pal_wdata;
    end
    pal_rdata <= pal_mem[pal_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      gam_mem[clr_cnt] <= {GAMMA_CHANNELS{clr_cnt}};
    end else if (load_we) begin
      gam_mem[s_data.entry_index][8*TBL_W'(s_data.gamma_channel) +: 8] <=
        s_data.gamma_value;
    end
    g_rdata <= gam_mem[g_raddr];
  end

  always_ff @(posedge clk) begin
    p_r <= 24'(col_r) * 24'(W_RED);
    p_g <= 24'(col_g) * 24'(W_GREEN);
    p_b <= 24'(col_b) * 24'(W_BLUE);
    glane <= tsel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      m_tvalid   <= 1'b0;
      luma_en    <= 1'b0;
      direct     <= 1'b0;
      gamma_en   <= 1'b1;
      gamma_3ch  <= 1'b0;
      index_bits <= MAX_INDEX_BITS;
      gch        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LUMA_EN:    luma_en    <= cfg_data[0];
          CFG_DIRECT:     direct     <= cfg_data[0];
          CFG_GAMMA_EN:   gamma_en   <= cfg_data[0];
          CFG_GAMMA_3CH:  gamma_3ch  <= cfg_data[0];
          CFG_GAMMA_BITS: index_bits <= cfg_data;
          default: ;
        endcase
      end
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 8'd1;
          if (clr_cnt == 8'hff) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            item_idx   <= s_data.entry_index;
            col_r      <= s_data.red_in[15:8];
            col_g      <= s_data.green_in[15:8];
            col_b      <= s_data.blue_in[15:8];
            case (s_tuser)
              OP_SET_IDX, OP_SET_DIR: begin
                if ((s_tuser == OP_SET_DIR) != direct) begin
                  res_status <= 1'b1;
                  state      <= ST_RES;
                end else begin
                  res_status <= 1'b0;
                  state      <= ST_MUL;
                end
              end
              OP_GET: begin
                res_status <= 1'b0;
                state      <= ST_GET;
              end
              default: begin
                res_status <= 1'b0;
                state      <= ST_RES;
              end
            endcase
          end
        end
        ST_MUL: state <= ST_SUM;
        ST_SUM: begin
          if (luma_en && !direct) begin
            col_r <= luma_sum[23:16];
            col_g <= luma_sum[23:16];
            col_b <= luma_sum[23:16];
          end
          gch   <= '0;
          state <= gamma_en ? ST_GAM : ST_WR;
        end
        ST_GAM: begin
          gch <= gch + 2'd1;
          case (gch)
            2'd1:    col_r <= g_byte;
            2'd2:    col_g <= g_byte;
            2'd3:    col_b <= g_byte;
            default: ;
          endcase
          if (gch == 2'd3) begin
            state <= ST_WR;
          end
        end
        ST_WR, ST_RES: begin
          if (out_free) begin
            m_tdata  <= '0;
            m_tuser  <= (state == ST_RES) ? res_status : 1'b0;
            state    <= ST_IDLE;
          end
        end
        ST_GET: begin
          if (out_free) begin
            m_tuser  <= 1'b0;
            if (item_in_pal) begin
              m_tdata <= out_data_t'({pal_rdata[23:16], pal_rdata[23:16],
                                      pal_rdata[15:8], pal_rdata[15:8],
                                      pal_rdata[7:0], pal_rdata[7:0]});
            end else begin
              m_tdata <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/pgc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgc_checker
// port-level checks on the palette lookup table, bound to the top level
// ----------------------------------------------------------------------------
module pgc_checker
  import pgc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  // fill pass keeps the command side closed right after reset
  a_fill_closed: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("command accepted during fill pass");

  // one command in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second command accepted while busy");

  // an error beat carries no colors
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("error beat with nonzero colors");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result beat changed while stalled");

endmodule

bind palette_gamma_clut pgc_checker u_pgc_checker (.*);

// ===== verif/palette_gamma_clut_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_gamma_clut_tb
// self-checking bench for the palette lookup table with gamma correction.
// a shadow copy of the palette, the gamma tables and the registers predicts
// every reply beat; replies are checked in order, field by field. a short
// directed run covers reset contents, kind errors, ignored loads, luminance
// and index-bit saturation, then random phases sweep register settings with
// random gaps on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module palette_gamma_clut_tb;
  import pgc_pkg::*;

  localparam int PAL_ENTRIES  = 256;
  localparam int GAMMA_TABLES = 3;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASES       = 16;
  localparam int PHASE_BEATS  = 120;

  typedef struct {
    out_data_t colors;
    logic      status;
  } reply_t;

  class clut_scoreboard;
    logic [7:0] pal_shadow [PAL_ENTRIES][3];
    logic [7:0] gamma_shadow [GAMMA_TABLES][256];
    logic       luma_on;
    logic       direct_on;
    logic       gamma_on;
    logic       three_tables;
    logic [3:0] gamma_bits;
    reply_t     expected_replies[$];
    int         failures;
    int         replies_checked;
    int         sets_stored;
    int         kind_errors;
    int         gets;
    int         loads;

    function new();
      for (int e = 0; e < PAL_ENTRIES; e++)
        for (int c = 0; c < 3; c++) pal_shadow[e][c] = MID_GRAY;
      for (int t = 0; t < GAMMA_TABLES; t++)
        for (int i = 0; i < 256; i++) gamma_shadow[t][i] = 8'(i);
      luma_on      = 1'b0;
      direct_on    = 1'b0;
      gamma_on     = 1'b1;
      three_tables = 1'b0;
      gamma_bits   = 4'd8;
      failures = 0;
      replies_checked = 0;
      sets_stored = 0;
      kind_errors = 0;
      gets = 0;
      loads = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_LUMA_EN:    luma_on = val[0];
        CFG_DIRECT:     direct_on = val[0];
        CFG_GAMMA_EN:   gamma_on = val[0];
        CFG_GAMMA_3CH:  three_tables = val[0];
        CFG_GAMMA_BITS: gamma_bits = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] gamma_lookup(int ch, logic [7:0] v);
      int bits;
      int table_sel;
      logic [7:0] idx;
      bits = (gamma_bits > 4'd8) ? 8 : int'(gamma_bits);
      idx = v >> (8 - bits);
      table_sel = (three_tables && ch < GAMMA_TABLES) ? ch : 0;
      return gamma_shadow[table_sel][idx];
    endfunction

    function void note_command(logic [1:0] op, in_data_t d);
      reply_t     r;
      logic [7:0] col [3];
      logic [31:0] sum;
      logic       want_direct;
      r.colors = '0;
      r.status = 1'b0;
      col[0] = d.red_in[15:8];
      col[1] = d.green_in[15:8];
      col[2] = d.blue_in[15:8];
      case (op)
        OP_SET_IDX, OP_SET_DIR: begin
          want_direct = (op == OP_SET_DIR);
          if (want_direct != direct_on) begin
            r.status = 1'b1;
            kind_errors++;
          end else begin
            if (luma_on && !direct_on) begin
              sum = 32'(col[0]) * 32'(W_RED) + 32'(col[1]) * 32'(W_GREEN)
                  + 32'(col[2]) * 32'(W_BLUE);
              for (int c = 0; c < 3; c++) col[c] = sum[23:16];
            end
            if (gamma_on)
              for (int c = 0; c < 3; c++) col[c] = gamma_lookup(c, col[c]);
            if (int'(d.entry_index) < PAL_ENTRIES)
              for (int c = 0; c < 3; c++) pal_shadow[d.entry_index][c] = col[c];
            sets_stored++;
          end
        end
        OP_GET: begin
          gets++;
          if (int'(d.entry_index) < PAL_ENTRIES) begin
            r.colors.red_out   = 16'(pal_shadow[d.entry_index][0]) * 16'h0101;
            r.colors.green_out = 16'(pal_shadow[d.entry_index][1]) * 16'h0101;
            r.colors.blue_out  = 16'(pal_shadow[d.entry_index][2]) * 16'h0101;
          end
        end
        default: begin
          loads++;
          if (int'(d.gamma_channel) < GAMMA_TABLES)
            gamma_shadow[d.gamma_channel][d.entry_index] = d.gamma_value;
        end
      endcase
      expected_replies.push_back(r);
    endfunction

    function void check_reply(out_data_t got, logic st);
      reply_t want;
      if (expected_replies.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("reply beat with nothing pending: r %h g %h b %h status %b",
                   got.red_out, got.green_out, got.blue_out, st);
        return;
      end
      want = expected_replies.pop_front();
      replies_checked++;
      if (got.red_out !== want.colors.red_out || got.green_out !== want.colors.green_out ||
          got.blue_out !== want.colors.blue_out || st !== want.status) begin
        failures++;
        if (failures <= 10)
          $display("reply %0d: expected r %h g %h b %h status %b, got r %h g %h b %h status %b",
                   replies_checked, want.colors.red_out, want.colors.green_out,
                   want.colors.blue_out, want.status, got.red_out, got.green_out,
                   got.blue_out, st);
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  clut_scoreboard board;
  int  idle_cycles;
  int  settings_done;
  bit  quiet;
  bit  hold_done;

  palette_gamma_clut #(
    .PALETTE_ENTRIES(PAL_ENTRIES),
    .GAMMA_CHANNELS (GAMMA_TABLES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (s_tvalid && s_tready) board.note_command(s_tuser, in_data_t'(s_tdata));
      if (m_tvalid && m_tready) board.check_reply(out_data_t'(m_tdata), m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("palette_gamma_clut verification failed");
        $finish;
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && board.replies_checked >= 200) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  task automatic send(logic [1:0] op, in_data_t d);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fields(logic [1:0] op, logic [7:0] idx, logic [15:0] r,
                             logic [15:0] g, logic [15:0] b, logic [1:0] ch,
                             logic [7:0] val);
    in_data_t d;
    d.pad           = '0;
    d.entry_index   = idx;
    d.red_in        = r;
    d.green_in      = g;
    d.blue_in       = b;
    d.gamma_channel = ch;
    d.gamma_value   = val;
    send(op, d);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  // upper bits of the one-bit registers carry noise
  task automatic apply_setting(bit lum, bit dir, bit gam, bit three, logic [3:0] bits);
    wait_drained();
    write_reg(CFG_LUMA_EN,    (4'($urandom) & 4'he) | 4'(lum));
    write_reg(CFG_DIRECT,     (4'($urandom) & 4'he) | 4'(dir));
    write_reg(CFG_GAMMA_EN,   (4'($urandom) & 4'he) | 4'(gam));
    write_reg(CFG_GAMMA_3CH,  (4'($urandom) & 4'he) | 4'(three));
    write_reg(CFG_GAMMA_BITS, bits);
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(5, 7)), 4'($urandom));
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  function automatic logic [15:0] pick_color();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hffff;
    return 16'($urandom);
  endfunction

  task automatic send_random();
    int         r;
    logic [1:0] op;
    logic [7:0] idx;
    logic [1:0] ch;
    r = $urandom_range(0, 99);
    if (r < 35) op = board.direct_on ? OP_SET_DIR : OP_SET_IDX;
    else if (r < 42) op = board.direct_on ? OP_SET_IDX : OP_SET_DIR;
    else if (r < 75) op = OP_GET;
    else op = OP_LOAD;
    r = $urandom_range(0, 99);
    if (r < 40) idx = 8'($urandom_range(0, 7));
    else if (r < 45) idx = 8'hff;
    else idx = 8'($urandom);
    ch = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    send_fields(op, idx, pick_color(), pick_color(), pick_color(), ch, 8'($urandom));
  endtask

  initial begin
    board = new();
    settings_done = 0;
    quiet = 1'b0;
    hold_done = 1'b0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tuser   <= OP_GET;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset contents, kind error, ignored load, shared gamma table
    send_fields(OP_GET,     8'h00, 16'h0000, 16'h0000, 16'h0000, 2'd0, 8'h00);
    send_fields(OP_GET,     8'hff, 16'hffff, 16'hffff, 16'hffff, 2'd3, 8'hff);
    send_fields(OP_SET_IDX, 8'h00, 16'hffff, 16'h0000, 16'h8001, 2'd0, 8'h00);
    send_fields(OP_GET,     8'h00, 16'h0000, 16'h0000, 16'h0000, 2'd0, 8'h00);
    send_fields(OP_SET_DIR, 8'h01, 16'h1234, 16'h5678, 16'h9abc, 2'd0, 8'h00);
    send_fields(OP_GET,     8'h01, 16'h0000, 16'h0000, 16'h0000, 2'd0, 8'h00);
    send_fields(OP_LOAD,    8'hff, 16'h0000, 16'h0000, 16'h0000, 2'd0, 8'h12);
    send_fields(OP_LOAD,    8'h00, 16'h0000, 16'h0000, 16'h0000, 2'd1, 8'hab);
    send_fields(OP_LOAD,    8'h80, 16'h0000, 16'h0000, 16'h0000, 2'd3, 8'h55);
    send_fields(OP_SET_IDX, 8'hff, 16'hffff, 16'hffff, 16'hffff, 2'd0, 8'h00);
    send_fields(OP_GET,     8'hff, 16'h0000, 16'h0000, 16'h0000, 2'd0, 8'h00);
    send_fields(OP_SET_IDX, 8'h03, 16'h00ff, 16'h7fff, 16'h80ff, 2'd0, 8'h00);
    send_fields(OP_GET,     8'h03, 16'h0000, 16'h0000, 16'h0000, 2'd0, 8'h00);

    // luminance, per-channel tables, zero index bits
    apply_setting(1'b1, 1'b0, 1'b1, 1'b1, 4'd0);
    send_fields(OP_LOAD,    8'h00, 16'h0000, 16'h0000, 16'h0000, 2'd2, 8'h3c);
    send_fields(OP_SET_IDX, 8'h04, 16'hffff, 16'hffff, 16'hffff, 2'd0, 8'h00);
    send_fields(OP_GET,     8'h04, 16'h0000, 16'h0000, 16'h0000, 2'd0, 8'h00);
    send_fields(OP_LOAD,    8'h00, 16'h0000, 16'h0000, 16'h0000, 2'd0, 8'hff);
    send_fields(OP_SET_IDX, 8'h05, 16'h0000, 16'h0000, 16'h0000, 2'd0, 8'h00);
    send_fields(OP_GET,     8'h05, 16'h0000, 16'h0000, 16'h0000, 2'd0, 8'h00);

    // direct mode ignores luminance, index bits above eight saturate
    apply_setting(1'b1, 1'b1, 1'b1, 1'b0, 4'd15);
    send_fields(OP_SET_IDX, 8'h06, 16'hffff, 16'hffff, 16'hffff, 2'd0, 8'h00);
    send_fields(OP_SET_DIR, 8'h06, 16'hffff, 16'h1234, 16'h0000, 2'd0, 8'h00);
    send_fields(OP_GET,     8'h06, 16'h0000, 16'h0000, 16'h0000, 2'd0, 8'h00);

    // gamma off stores raw high bytes
    apply_setting(1'b0, 1'b1, 1'b0, 1'b1, 4'd8);
    send_fields(OP_SET_DIR, 8'h07, 16'habff, 16'hcd00, 16'hef55, 2'd0, 8'h00);
    send_fields(OP_GET,     8'h07, 16'h0000, 16'h0000, 16'h0000, 2'd0, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_setting(1'b0, 1'b0, 1'b0, 1'b0, 4'd8);
        1: apply_setting(1'b1, 1'b0, 1'b1, 1'b1, 4'd15);
        2: apply_setting(1'b1, 1'b1, 1'b1, 1'b0, 4'd0);
        3: apply_setting(1'b0, 1'b1, 1'b1, 1'b1, 4'd1);
        4: apply_setting(1'b1, 1'b0, 1'b1, 1'b0, 4'd8);
        default: apply_setting(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                               4'($urandom_range(0, 15)));
      endcase
      quiet = (p == 5 || p == 9);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (p == 6 && i == PHASE_BEATS / 2) wait_drained();
        send_random();
      end
    end
    quiet = 1'b0;

    wait_drained();
    $display("%0d commands: %0d stores, %0d kind errors, %0d gets, %0d gamma loads",
             board.sets_stored + board.kind_errors + board.gets + board.loads,
             board.sets_stored, board.kind_errors, board.gets, board.loads);
    $display("%0d replies checked over %0d register settings, %0d mismatches",
             board.replies_checked, settings_done, board.failures);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("palette_gamma_clut verification clean");
    end else begin
      $display("palette_gamma_clut verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pgc_pkg.sv
hdl/palette_gamma_clut.sv
hdl/pgc_checker.sv
verif/palette_gamma_clut_tb.sv
